/* rtl/ulwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulwc_pkg: shared types and constants for the UTF-8 line width clipper
// Transaction payloads, the front-to-back job record, UTF-8 lead byte codes
// and the display width classification of a code point.
// ----------------------------------------------------------------------------
package ulwc_pkg;

   // input transaction payload
   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       end_of_line;
   } req_type;

   // result transaction payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       line_done;
   } rsp_type;

   // work handed from front to back: character bytes to emit, then a newline if eol
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
      logic            eol;
   } job_type;

   // UTF-8 lead byte patterns
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   // payload masks of lead bytes
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;

   // control characters take no output
   localparam logic [20:0] FIRST_PRINTABLE = 21'h20;
   localparam logic [20:0] DEL_CODE        = 21'h7F;

   localparam logic [7:0] NEWLINE   = 8'h0A;
   localparam int         LIMIT_RST = 79;

   // display width in cells: 0 for combining marks, 2 for wide scripts
   function automatic logic [1:0] width_of(input logic [20:0] c);
      logic zero_w;
      logic wide_w;
      zero_w = (c >= 21'h00300 && c <= 21'h0036F) ||
               (c >= 21'h0200B && c <= 21'h0200F) ||
               (c >= 21'h0FE00 && c <= 21'h0FE0F);
      wide_w = (c >= 21'h01100 && c <= 21'h0115F) ||
               (c >= 21'h02E80 && c <= 21'h0A4CF) ||
               (c >= 21'h0AC00 && c <= 21'h0D7A3) ||
               (c >= 21'h0F900 && c <= 21'h0FAFF) ||
               (c >= 21'h0FE10 && c <= 21'h0FE6F) ||
               (c >= 21'h0FF01 && c <= 21'h0FF60) ||
               (c >= 21'h1F000 && c <= 21'h1FAFF) ||
               (c >= 21'h20000 && c <= 21'h3FFFF);
      if (zero_w) begin
         return 2'd0;
      end else if (wide_w) begin
         return 2'd2;
      end
      return 2'd1;
   endfunction

endpackage
`default_nettype wire

/* rtl/ulwc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulwc_front: UTF-8 decoder and column fit test
// Decodes one byte per transaction, tracks cells used on the line and hands
// each complete, fitting printable character (and the end of line) to the back end.
// ----------------------------------------------------------------------------
module ulwc_front #(
   parameter int LIMIT_BITS = 12
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    item_accept,
   input  wire ulwc_pkg::req_type item,
   input  wire                    csr_valid,
   input  wire  [LIMIT_BITS-1:0]  csr_data,
   output logic                   job_push,
   output ulwc_pkg::job_type      job
);
   import ulwc_pkg::*;

   logic [LIMIT_BITS-1:0] limit_ff;
   logic [20:0]           partial_ff, partial_in;
   logic [1:0]            rem_ff, rem_in;
   logic [2:0]            seq_ff, seq_in;
   logic [3:0][7:0]       held_ff, held_in;
   logic [LIMIT_BITS-1:0] used_ff, used_in;
   logic                  stopped_ff, stopped_in;

   logic [20:0]           code;
   logic                  fin;
   logic [2:0]            emit_cnt;
   logic [1:0]            size;
   logic [LIMIT_BITS:0]   sum;
   logic [1:0]            pos;
   logic [2:0]            pos_diff;
   logic [7:0]            b;

   assign b        = item.byte_value;
   assign pos_diff = seq_ff - {1'b0, rem_ff};
   assign pos      = pos_diff[1:0];

   // decode, fit test and next line state
   always_comb begin
      partial_in = partial_ff;
      rem_in     = rem_ff;
      seq_in     = seq_ff;
      held_in    = held_ff;
      used_in    = used_ff;
      stopped_in = stopped_ff;
      fin        = 1'b0;
      code       = partial_ff;
      emit_cnt   = 3'd0;

      if (item.has_byte && !stopped_ff) begin
         if (rem_ff == 2'd0) begin
            held_in[0] = b;
            priority if ((b & LEAD2_MASK) == LEAD2_CODE) begin
               partial_in = 21'(b & LEAD2_BITS);
               seq_in     = 3'd2;
               rem_in     = 2'd1;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
               partial_in = 21'(b & LEAD3_BITS);
               seq_in     = 3'd3;
               rem_in     = 2'd2;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
               partial_in = 21'(b & LEAD4_BITS);
               seq_in     = 3'd4;
               rem_in     = 2'd3;
            end else if (b[7]) begin
               // stray continuation or invalid lead
               stopped_in = 1'b1;
            end else begin
               partial_in = 21'(b);
               seq_in     = 3'd1;
               code       = 21'(b);
               fin        = 1'b1;
            end
         end else begin
            // continuation: low six bits only, not checked
            held_in[pos] = b;
            code         = {partial_ff[14:0], b[5:0]};
            partial_in   = code;
            rem_in       = rem_ff - 2'd1;
            fin          = (rem_ff == 2'd1);
         end
      end

      size = width_of(code);
      sum  = {1'b0, used_ff} + (LIMIT_BITS+1)'(size);

      if (fin) begin
         if (sum > {1'b0, limit_ff}) begin
            stopped_in = 1'b1;
         end else if (code >= FIRST_PRINTABLE && code != DEL_CODE) begin
            emit_cnt = seq_in;
            used_in  = sum[LIMIT_BITS-1:0];
         end
      end

      // end of line clears the line state
      if (item.end_of_line) begin
         partial_in = '0;
         rem_in     = '0;
         seq_in     = '0;
         used_in    = '0;
         stopped_in = 1'b0;
      end
   end

   assign job_push  = item_accept && (emit_cnt != 3'd0 || item.end_of_line);
   assign job.count = emit_cnt;
   assign job.bytes = held_in;
   assign job.eol   = item.end_of_line;

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         rem_ff     <= '0;
         seq_ff     <= '0;
         used_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (item_accept) begin
         partial_ff <= partial_in;
         rem_ff     <= rem_in;
         seq_ff     <= seq_in;
         used_ff    <= used_in;
         stopped_ff <= stopped_in;
      end
   end

   // held character bytes, no reset
   always_ff @(posedge clock) begin
      if (item_accept) begin
         held_ff <= held_in;
      end
   end

   // column limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_BITS'(LIMIT_RST);
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/ulwc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulwc_queue: job queue between front and back
// Small circular buffer of job records; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module ulwc_queue #(
   parameter int DEPTH = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire ulwc_pkg::job_type  push_job,
   input  wire                     pop,
   output logic                    full,
   output logic                    not_empty,
   output ulwc_pkg::job_type       head
);
   import ulwc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = store_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

/* rtl/ulwc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulwc_back: result serialiser
// Takes one job at a time and emits its character bytes, then the closing
// newline of an eol job; one result per unstalled cycle via an output register.
// ----------------------------------------------------------------------------
module ulwc_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     job_valid,
   input  wire ulwc_pkg::job_type  job,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output ulwc_pkg::rsp_type       rsp_data
);
   import ulwc_pkg::*;

   job_type    work_ff;
   logic       work_valid_ff;
   logic [2:0] pos_ff;
   logic       out_valid_ff;
   rsp_type    out_ff, out_in;
   logic       out_free;
   logic       adv;
   logic       is_char;
   logic       last;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign adv      = work_valid_ff && out_free;
   assign is_char  = (pos_ff < work_ff.count);
   assign last     = work_ff.eol ? (pos_ff == work_ff.count)
                                 : (pos_ff + 3'd1 == work_ff.count);
   assign job_pop  = job_valid && (!work_valid_ff || (adv && last));

   // next result from the working job
   always_comb begin
      if (is_char) begin
         out_in.out_byte  = work_ff.bytes[pos_ff[1:0]];
         out_in.line_done = 1'b0;
      end else begin
         out_in.out_byte  = NEWLINE;
         out_in.line_done = 1'b1;
      end
   end

   // working job and position
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         pos_ff        <= '0;
      end else if (job_pop) begin
         work_valid_ff <= 1'b1;
         pos_ff        <= '0;
      end else if (adv) begin
         work_valid_ff <= !last;
         pos_ff        <= pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         work_ff <= job;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= work_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

/* rtl/utf8_line_width_clip.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_line_width_clip: UTF-8 line decoder with display width clipping
// Passes the printable characters of a line until one overflows the column
// limit or a byte is invalid, and closes every line with a newline.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_*     in    req_valid / req_stall  ulwc_pkg::req_type (one byte)
//  rsp_*     out   rsp_valid / rsp_stall  ulwc_pkg::rsp_type (one byte)
//  csr_*     in    csr_valid / csr_ready  column_limit, LIMIT_BITS bits
//
//  A byte is accepted every cycle while the job queue has room; decode and
//  the fit test finish in the cycle of acceptance.
//  The serialiser gives one result per cycle while rsp_stall is low; an item
//  gives up to five, passing the queue, work register and output register.
//  Synchronous reset clears line state, queue and output, limit to 79.
//  rsp_stall holds the output register; the queue keeps the front running
//  until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module utf8_line_width_clip #(
   parameter int LIMIT_BITS  = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire ulwc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ulwc_pkg::rsp_type      rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [LIMIT_BITS-1:0]  csr_data
);
   import ulwc_pkg::*;

   logic    q_full;
   logic    q_not_empty;
   logic    item_accept;
   logic    job_push;
   logic    job_pop;
   job_type job_in;
   job_type job_head;

   assign req_stall   = q_full;
   assign item_accept = req_valid && !q_full;
   assign csr_ready   = 1'b1;

   ulwc_front #(
      .LIMIT_BITS (LIMIT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (req_data),
      .csr_valid   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .job_push    (job_push),
      .job         (job_in)
   );

   ulwc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (job_in),
      .pop       (job_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (job_head)
   );

   ulwc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_not_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/ulwc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulwc_checker: port-level checks for the line width clipper
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module ulwc_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_stall,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire ulwc_pkg::rsp_type rsp_data
);
   import ulwc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // the line closing result is always a newline
   a_done_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_done |-> rsp_data.out_byte == NEWLINE)
      else $error("line_done without newline byte");

   // reset empties the output register
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset empties the job queue, so input is not stalled
   a_reset_in: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind utf8_line_width_clip ulwc_checker u_ulwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UTF-8 line width clipper
// Feeds lines of UTF-8 bytes (directed corner cases, then random lines of
// well-formed, overlong, cut-off and corrupted characters) under several
// column limits, with bursty input and a stalling receiver. A behavioural
// decoder predicts every output byte and the closing newline of each line.
// ----------------------------------------------------------------------------
module tb_top;
   import ulwc_pkg::*;

   localparam int         LIMIT_W     = 12;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         RANDOM_BYTES = 120;
   localparam int         SETTLE_CYCLES = 20;
   localparam logic [7:0] CONT_MARK   = 8'h80;
   localparam int         MAX_PRINTS  = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_data = '0;

   utf8_line_width_clip #(.LIMIT_BITS(LIMIT_W)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench bookkeeping
   req_type pending_bytes[$];
   req_type line_items[$];
   rsp_type out_due[$];
   rsp_type due_head;
   int      fail_count = 0;
   int      cycle_count = 0;
   int      items_sent = 0;
   int      items_taken = 0;
   int      bytes_queued = 0;
   bit      req_took = 1'b0;
   int      gap_left = 0;
   int      burst_left = 0;
   int      stall_left = 0;
   int      run_left = 0;

   // decoder model state
   logic [LIMIT_W-1:0] lim_cells = LIMIT_W'(LIMIT_RST);
   logic [20:0]        code_acc = '0;
   logic [1:0]         cont_left = '0;
   logic [2:0]         seq_len = '0;
   logic [7:0]         held [0:3];
   logic [LIMIT_W-1:0] cells_used = '0;
   logic               line_stopped = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < MAX_PRINTS) begin
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      end
      fail_count++;
   endtask

   // display cells of a code point: combining marks 0, wide scripts 2
   function automatic int display_cells(input logic [20:0] cp);
      int cells;
      cells = 1;
      if ((cp >= 21'h01100 && cp <= 21'h0115F) || (cp >= 21'h02E80 && cp <= 21'h0A4CF) ||
          (cp >= 21'h0AC00 && cp <= 21'h0D7A3) || (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
          (cp >= 21'h0FE10 && cp <= 21'h0FE6F) || (cp >= 21'h0FF01 && cp <= 21'h0FF60) ||
          (cp >= 21'h1F000 && cp <= 21'h1FAFF) || (cp >= 21'h20000 && cp <= 21'h3FFFF)) begin
         cells = 2;
      end
      if ((cp >= 21'h00300 && cp <= 21'h0036F) || (cp >= 21'h0200B && cp <= 21'h0200F) ||
          (cp >= 21'h0FE00 && cp <= 21'h0FE0F)) begin
         cells = 0;
      end
      return cells;
   endfunction

   function automatic rsp_type make_out(input logic [7:0] b, input logic done);
      rsp_type r;
      r.out_byte  = b;
      r.line_done = done;
      return r;
   endfunction

   // fit test on a completed character; printable ones are passed through
   task automatic close_char();
      int cells;
      int i;
      cells = display_cells(code_acc);
      if (int'(cells_used) + cells > int'(lim_cells)) begin
         line_stopped = 1'b1;
      end else if (code_acc >= FIRST_PRINTABLE && code_acc != DEL_CODE) begin
         for (i = 0; i < int'(seq_len) && i < 4; i++) begin
            out_due.push_back(make_out(held[i], 1'b0));
         end
         cells_used = cells_used + LIMIT_W'(cells);
      end
   endtask

   // decode one accepted byte and queue the bytes it lets through
   task automatic decode_and_clip(input req_type it);
      logic [7:0] b;
      int         pos;
      b = it.byte_value;
      if (it.has_byte && !line_stopped) begin
         if (cont_left == 2'd0) begin
            held[0] = b;
            if ((b & LEAD2_MASK) == LEAD2_CODE) begin
               code_acc  = {13'd0, b & LEAD2_BITS};
               seq_len   = 3'd2;
               cont_left = 2'd1;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
               code_acc  = {13'd0, b & LEAD3_BITS};
               seq_len   = 3'd3;
               cont_left = 2'd2;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
               code_acc  = {13'd0, b & LEAD4_BITS};
               seq_len   = 3'd4;
               cont_left = 2'd3;
            end else if (b[7]) begin
               // stray continuation or invalid lead byte
               line_stopped = 1'b1;
            end else begin
               code_acc = {13'd0, b};
               seq_len  = 3'd1;
               close_char();
            end
         end else begin
            // continuation: any byte, low six bits only
            pos = (int'(seq_len) - int'(cont_left)) & 3;
            held[pos] = b;
            code_acc  = {code_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               close_char();
            end
         end
      end
      if (it.end_of_line) begin
         out_due.push_back(make_out(NEWLINE, 1'b1));
         code_acc     = '0;
         cont_left    = '0;
         seq_len      = '0;
         cells_used   = '0;
         line_stopped = 1'b0;
      end
   endtask

   // monitor: timeout, result checks, then prediction of accepted transactions
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         if (!reset && rsp_valid && !rsp_stall) begin
            if (out_due.size() == 0) begin
               report_mismatch("result with nothing due", int'(rsp_data.out_byte), 0);
            end else begin
               due_head = out_due.pop_front();
               if (rsp_data.out_byte !== due_head.out_byte) begin
                  report_mismatch("out_byte", int'(rsp_data.out_byte),
                                  int'(due_head.out_byte));
               end
               if (rsp_data.line_done !== due_head.line_done) begin
                  report_mismatch("line_done", int'(rsp_data.line_done),
                                  int'(due_head.line_done));
               end
            end
         end
         if (!reset && req_valid && !req_stall) begin
            decode_and_clip(req_data);
            items_taken++;
         end
         req_took <= !reset && req_valid && !req_stall;
      end
   end

   // driver: bursts with random gaps; receiver stalls in runs of its own
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // transaction still waiting, hold it
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
         req_valid <= 1'b1;
         req_data  <= pending_bytes.pop_front();
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end

      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else begin
         run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
         stall_left = $urandom_range(0, 7);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) begin
            stall_left--;
         end
      end
   end

   // line assembly
   task automatic put(input logic [7:0] b, input logic has, input logic eol);
      req_type it;
      it.byte_value  = b;
      it.has_byte    = has;
      it.end_of_line = eol;
      line_items.push_back(it);
   endtask

   // continuation byte, now and then replaced by any byte at all
   task automatic put_cont(input logic [7:0] b);
      if ($urandom_range(0, 19) == 0) begin
         put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else begin
         put(b, 1'b1, 1'b0);
      end
   endtask

   task automatic put_encoded(input logic [20:0] cp, input int len, input int keep);
      logic [7:0] enc [0:3];
      int         i;
      enc[1] = CONT_MARK | {2'b00, cp[5:0]};
      enc[2] = CONT_MARK | {2'b00, cp[5:0]};
      enc[3] = CONT_MARK | {2'b00, cp[5:0]};
      case (len)
         1: begin
            enc[0] = {1'b0, cp[6:0]};
         end
         2: begin
            enc[0] = LEAD2_CODE | {3'b000, cp[10:6]};
         end
         3: begin
            enc[0] = LEAD3_CODE | {4'b0000, cp[15:12]};
            enc[1] = CONT_MARK | {2'b00, cp[11:6]};
         end
         default: begin
            enc[0] = LEAD4_CODE | {5'b00000, cp[20:18]};
            enc[1] = CONT_MARK | {2'b00, cp[17:12]};
            enc[2] = CONT_MARK | {2'b00, cp[11:6]};
         end
      endcase
      put(enc[0], 1'b1, 1'b0);
      for (i = 1; i < keep; i++) begin
         put_cont(enc[i]);
      end
   endtask

   function automatic logic [20:0] edge_point();
      case ($urandom_range(0, 31))
         0:  return 21'h002FF;
         1:  return 21'h00300;
         2:  return 21'h0036F;
         3:  return 21'h00370;
         4:  return 21'h0200A;
         5:  return 21'h0200B;
         6:  return 21'h0200F;
         7:  return 21'h02010;
         8:  return 21'h010FF;
         9:  return 21'h01100;
         10: return 21'h0115F;
         11: return 21'h01160;
         12: return 21'h02E7F;
         13: return 21'h02E80;
         14: return 21'h0A4CF;
         15: return 21'h0A4D0;
         16: return 21'h0ABFF;
         17: return 21'h0AC00;
         18: return 21'h0D7A3;
         19: return 21'h0D7A4;
         20: return 21'h0F8FF;
         21: return 21'h0FAFF;
         22: return 21'h0FDFF;
         23: return 21'h0FE0F;
         24: return 21'h0FE10;
         25: return 21'h0FE6F;
         26: return 21'h0FF00;
         27: return 21'h0FF60;
         28: return 21'h1EFFF;
         29: return 21'h1FAFF;
         30: return 21'h1FFFF;
         default: return 21'h40000;
      endcase
   endfunction

   function automatic logic [20:0] wide_point();
      case ($urandom_range(0, 7))
         0: return 21'($urandom_range('h01100, 'h0115F));
         1: return 21'($urandom_range('h02E80, 'h0A4CF));
         2: return 21'($urandom_range('h0AC00, 'h0D7A3));
         3: return 21'($urandom_range('h0F900, 'h0FAFF));
         4: return 21'($urandom_range('h0FE10, 'h0FE6F));
         5: return 21'($urandom_range('h0FF01, 'h0FF60));
         6: return 21'($urandom_range('h1F000, 'h1FAFF));
         default: return 21'($urandom_range('h20000, 'h3FFFF));
      endcase
   endfunction

   function automatic int natural_len(input logic [20:0] cp);
      if (cp < 21'h80) begin
         return 1;
      end else if (cp < 21'h800) begin
         return 2;
      end else if (cp < 21'h10000) begin
         return 3;
      end
      return 4;
   endfunction

   // one random character: mostly well formed, some overlong, some noise
   task automatic add_char();
      int          pick;
      int          len;
      logic [20:0] cp;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         return;
      end
      if (pick < 15) begin
         cp = ($urandom_range(0, 1) == 0) ? DEL_CODE : 21'($urandom_range(0, 31));
      end else if (pick < 45) begin
         cp = 21'($urandom_range(32, 126));
      end else if (pick < 55) begin
         cp = edge_point();
      end else if (pick < 63) begin
         cp = 21'($urandom_range('h80, 'h7FF));
      end else if (pick < 70) begin
         case ($urandom_range(0, 2))
            0: cp = 21'($urandom_range('h0300, 'h036F));
            1: cp = 21'($urandom_range('h200B, 'h200F));
            default: cp = 21'($urandom_range('hFE00, 'hFE0F));
         endcase
      end else if (pick < 85) begin
         cp = wide_point();
      end else if (pick < 93) begin
         cp = 21'($urandom_range('h800, 'hFFFF));
      end else begin
         cp = 21'($urandom_range('h10000, 'h1FFFFF));
      end
      len = natural_len(cp);
      if (len < 4 && $urandom_range(0, 19) == 0) begin
         len++;
      end
      put_encoded(cp, len, len);
   endtask

   task automatic build_random_line();
      int      n;
      int      i;
      int      tail;
      int      len;
      req_type last;
      n = $urandom_range(0, 9);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         add_char();
      end
      tail = $urandom_range(0, 9);
      if (tail < 2) begin
         // character cut off by the end of the line
         len = $urandom_range(2, 4);
         put_encoded(21'($urandom_range(0, 'h1FFFFF)), len, $urandom_range(1, len - 1));
      end
      if (tail == 2 || line_items.size() == 0) begin
         put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
         last = line_items.pop_back();
         last.end_of_line = 1'b1;
         line_items.push_back(last);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (items_taken != items_sent || out_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // hand the assembled line to the driver; a split pauses the sender mid-line
   task automatic send_line(input int split);
      int i;
      @(posedge clock);
      for (i = 0; i < line_items.size(); i++) begin
         if (i == split && i != 0) begin
            drain();
            @(posedge clock);
         end
         pending_bytes.push_back(line_items[i]);
         items_sent++;
         if (line_items[i].has_byte) begin
            bytes_queued++;
         end
      end
      line_items.delete();
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      lim_cells = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit(input int phase);
      case (phase)
         0: return '0;
         1: return '1;
         2: return LIMIT_W'(1);
         3: return LIMIT_W'(5);
         default: begin
            case ($urandom_range(0, 4))
               0: return LIMIT_W'($urandom_range(0, 4));
               1: return LIMIT_W'($urandom_range(4, 16));
               2: return LIMIT_W'(LIMIT_RST);
               3: return '1;
               default: return LIMIT_W'($urandom_range(0, 4095));
            endcase
         end
      endcase
   endfunction

   // stimulus sequence
   initial begin
      int phase;
      int line_no;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset limit: controls, extremes of printable range, each
      // sequence length, combining mark, overlong control, unchecked
      // continuation bytes, empty end-of-line transaction
      put(8'h41, 1'b1, 1'b0); put(8'h00, 1'b1, 1'b0); put(8'h7F, 1'b1, 1'b0);
      put(8'h20, 1'b1, 1'b0); put(8'h7E, 1'b1, 1'b0); put(8'hC3, 1'b1, 1'b0);
      put(8'hA9, 1'b1, 1'b0); put(8'hCC, 1'b1, 1'b0); put(8'h81, 1'b1, 1'b0);
      put(8'hE4, 1'b1, 1'b0); put(8'hB8, 1'b1, 1'b0); put(8'hAD, 1'b1, 1'b0);
      put(8'hF0, 1'b1, 1'b0); put(8'h9F, 1'b1, 1'b0); put(8'h98, 1'b1, 1'b0);
      put(8'h80, 1'b1, 1'b0); put(8'hC0, 1'b1, 1'b0); put(8'h81, 1'b1, 1'b0);
      put(8'hE4, 1'b1, 1'b0); put(8'h41, 1'b1, 1'b0); put(8'h41, 1'b1, 1'b0);
      put(8'h00, 1'b0, 1'b1);
      send_line(-1);
      // stray continuation stops the line; bytes after it are ignored
      put(8'h80, 1'b1, 1'b0); put(8'h42, 1'b1, 1'b0); put(8'h43, 1'b1, 1'b1);
      send_line(-1);
      // invalid lead bytes
      put(8'hF8, 1'b1, 1'b1);
      send_line(-1);
      put(8'hFF, 1'b1, 1'b1);
      send_line(-1);
      // cut-off sequence, then an empty transaction without end of line
      put(8'hE4, 1'b1, 1'b0); put(8'hB8, 1'b1, 1'b1);
      send_line(-1);
      put(8'h7E, 1'b0, 1'b0); put(8'hFF, 1'b0, 1'b1);
      send_line(-1);

      // character too wide for the remaining cells
      write_limit(LIMIT_W'(2));
      put(8'h61, 1'b1, 1'b0); put(8'hE4, 1'b1, 1'b0); put(8'hB8, 1'b1, 1'b0);
      put(8'hAD, 1'b1, 1'b0); put(8'h62, 1'b1, 1'b1);
      send_line(-1);

      // random lines over a series of limits
      bytes_queued = 0;
      phase = 0;
      while (bytes_queued < RANDOM_BYTES) begin
         write_limit(pick_limit(phase));
         for (line_no = 0; line_no < 6; line_no++) begin
            build_random_line();
            if (phase == 1 && line_no == 0) begin
               send_line(line_items.size() / 2);
            end else begin
               send_line(-1);
            end
         end
         phase++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
